// ----- rtl/aqp_pkg.sv -----
// Shared types, constants and helper functions of the quadrature allpass pair.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package aqp_pkg;

   localparam int SAMPLE_WIDTH      = 16;
   localparam int INTERNAL_WIDTH    = 24;
   localparam int SECTIONS_PER_PATH = 4;

   localparam int COEF_WIDTH   = 16;
   localparam int COEF_FRAC    = 16;
   localparam int NUM_REGS     = 8;
   localparam int REG_IDX_W    = 3;
   localparam int REGS_PER_PATH = 4;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   // Path select codes.
   localparam logic PATH_IN_PHASE   = 1'b0;
   localparam logic PATH_QUADRATURE = 1'b1;

   // Product of (x + y2) by the coefficient, and the difference after rounding.
   localparam int SUM_WIDTH  = INTERNAL_WIDTH + 1;
   localparam int PROD_WIDTH = SUM_WIDTH + COEF_WIDTH + 1;
   localparam int DIFF_WIDTH = PROD_WIDTH - COEF_FRAC + 1;

   localparam logic [0:NUM_REGS-1][COEF_WIDTH-1:0] COEF_RESET = '{
      16'd31418, 16'd57424, 16'd64002, 16'd65372,
      16'd10601, 16'd48040, 16'd61954, 16'd64920
   };

   // Word handed from one section cell to the next.
   typedef struct packed {
      logic                             valid;
      logic signed [INTERNAL_WIDTH-1:0] data;
   } aqp_link_type;

   // Register of a section; sections past the last register reuse it.
   function automatic logic [REG_IDX_W-1:0] coef_index(input logic path, input int k);
      int reg_k;
      reg_k = (k < REGS_PER_PATH - 1) ? k : REGS_PER_PATH - 1;
      return REG_IDX_W'(int'(path) * REGS_PER_PATH + reg_k);
   endfunction

   // Clamp a section difference to the internal width.
   function automatic logic signed [INTERNAL_WIDTH-1:0] sat_to_internal(
      input logic signed [DIFF_WIDTH-1:0] v);
      logic signed [DIFF_WIDTH-1:0] hi;
      logic signed [DIFF_WIDTH-1:0] lo;
      hi = {{(DIFF_WIDTH-INTERNAL_WIDTH+1){1'b0}}, {(INTERNAL_WIDTH-1){1'b1}}};
      lo = {{(DIFF_WIDTH-INTERNAL_WIDTH+1){1'b1}}, {(INTERNAL_WIDTH-1){1'b0}}};
      if (v > hi) begin
         return hi[INTERNAL_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[INTERNAL_WIDTH-1:0];
      end
      return v[INTERNAL_WIDTH-1:0];
   endfunction

   // Clamp an internal value to the sample width.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_to_sample(
      input logic signed [INTERNAL_WIDTH-1:0] v);
      logic signed [INTERNAL_WIDTH-1:0] hi;
      logic signed [INTERNAL_WIDTH-1:0] lo;
      hi = {{(INTERNAL_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
      lo = {{(INTERNAL_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
      if (v > hi) begin
         return hi[SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_WIDTH-1:0];
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/allpass_quadrature_pair.sv -----
// Top level of the quadrature allpass pair: CSR block, two chains of section
// cells, one-sample delay and result buffer. Depends on aqp_pkg and aqp_cell.
//
// Usage:
//   req_ channel: one signed sample per word (req_valid / req_stall).
//   rsp_ channel: one word per sample with in_phase, quadrature and mixed
//   (rsp_valid / rsp_stall). A word moves when valid is high and stall low.
//   csr_ port: APB-style, eight 16-bit coefficient registers at 4*i; write
//   them only while the block is idle.
// Timing: each path is a chain of four cells, each a multiply step, then a
//   round/subtract/clamp step; the last cells' outputs are registered into the
//   output register before the word shows on rsp_. The chain holds one sample
//   at a time and frees on the edge that loads the word, so a new sample is
//   taken only once the previous one has left the chain.
// Stall: a finished word waits in the output register; one more sample may
//   be accepted and its result parks in a second slot, then req_stall holds
//   until the output register passes its word on.
// Reset: coefficients return to their defaults, all section histories and the
//   in-phase delay clear to zero, and both channels go empty.
`default_nettype none

module allpass_quadrature_pair import aqp_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_in_phase,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_quadrature,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_mixed,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]               csr_prdata,
   output logic                                csr_pready
);

   localparam int CHAIN_LATENCY = 2 * SECTIONS_PER_PATH;

   // ---------------- configuration registers ----------------
   logic [0:NUM_REGS-1][COEF_WIDTH-1:0] coef_ff;
   logic [REG_IDX_W-1:0]                csr_index;
   logic                                csr_write;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-COEF_WIDTH){1'b0}}, coef_ff[csr_index]};

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_write) begin
         coef_ff[csr_index] <= csr_pwdata[COEF_WIDTH-1:0];
      end
   end

   // ---------------- section chains ----------------
   logic         req_accept;
   aqp_link_type i_link [0:SECTIONS_PER_PATH];
   aqp_link_type q_link [0:SECTIONS_PER_PATH];
   logic         chain_done;

   assign req_accept = req_valid & ~req_stall;

   // Both chains start on the same sample, widened to the internal width.
   assign i_link[0].valid = req_accept;
   assign i_link[0].data  =
      {{(INTERNAL_WIDTH-SAMPLE_WIDTH){req_sample[SAMPLE_WIDTH-1]}}, req_sample};
   assign q_link[0] = i_link[0];

   for (genvar k = 0; k < SECTIONS_PER_PATH; k++) begin : g_sec
      aqp_cell u_cell_i (
         .clock    (clock),
         .reset    (reset),
         .link_in  (i_link[k]),
         .coef     (coef_ff[coef_index(PATH_IN_PHASE, k)]),
         .link_out (i_link[k+1])
      );
      aqp_cell u_cell_q (
         .clock    (clock),
         .reset    (reset),
         .link_in  (q_link[k]),
         .coef     (coef_ff[coef_index(PATH_QUADRATURE, k)]),
         .link_out (q_link[k+1])
      );
   end

   assign chain_done = i_link[SECTIONS_PER_PATH].valid;

   // ---------------- result forming ----------------
   logic                             busy_ff;
   logic                             busy_in;
   logic signed [INTERNAL_WIDTH-1:0] path_delay_ff;
   logic signed [INTERNAL_WIDTH:0]   pair_sum;
   logic signed [SAMPLE_WIDTH-1:0]   new_in_phase;
   logic signed [SAMPLE_WIDTH-1:0]   new_quadrature;
   logic signed [SAMPLE_WIDTH-1:0]   new_mixed;

   // Mix the delayed in-phase with the current quadrature before clamping.
   assign pair_sum = {path_delay_ff[INTERNAL_WIDTH-1], path_delay_ff}
                   + {q_link[SECTIONS_PER_PATH].data[INTERNAL_WIDTH-1],
                      q_link[SECTIONS_PER_PATH].data};
   assign new_in_phase   = sat_to_sample(path_delay_ff);
   assign new_quadrature = sat_to_sample(q_link[SECTIONS_PER_PATH].data);
   assign new_mixed      = sat_to_sample(pair_sum[INTERNAL_WIDTH:1]);

   // Hold the chain busy from acceptance until the last cells report.
   always_comb begin
      priority if (req_accept) begin
         busy_in = 1'b1;
      end else if (chain_done) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         path_delay_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (chain_done) begin
            path_delay_ff <= i_link[SECTIONS_PER_PATH].data;
         end
      end
   end

   // ---------------- output register and parking slot ----------------
   logic                           rsp_valid_ff;
   logic                           pend_valid_ff;
   logic                           rsp_take;
   logic                           load_rsp;
   logic                           load_pend;
   logic                           drain_pend;
   logic signed [SAMPLE_WIDTH-1:0] rsp_in_phase_ff, rsp_quadrature_ff, rsp_mixed_ff;
   logic signed [SAMPLE_WIDTH-1:0] pend_in_phase_ff, pend_quadrature_ff, pend_mixed_ff;

   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign load_rsp   = chain_done & (~rsp_valid_ff | rsp_take);
   assign load_pend  = chain_done & rsp_valid_ff & ~rsp_take;
   assign drain_pend = ~chain_done & rsp_take & pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         priority if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (drain_pend) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (load_pend) begin
            pend_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= rsp_valid_ff;
            pend_valid_ff <= pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_in_phase_ff   <= new_in_phase;
         rsp_quadrature_ff <= new_quadrature;
         rsp_mixed_ff      <= new_mixed;
      end else if (drain_pend) begin
         rsp_in_phase_ff   <= pend_in_phase_ff;
         rsp_quadrature_ff <= pend_quadrature_ff;
         rsp_mixed_ff      <= pend_mixed_ff;
      end
      if (load_pend) begin
         pend_in_phase_ff   <= new_in_phase;
         pend_quadrature_ff <= new_quadrature;
         pend_mixed_ff      <= new_mixed;
      end
   end

   // Take no sample while the chain runs or a word is parked.
   assign req_stall      = busy_ff | pend_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_in_phase   = rsp_in_phase_ff;
   assign rsp_quadrature = rsp_quadrature_ff;
   assign rsp_mixed      = rsp_mixed_ff;

   // ---------------- assertions ----------------
   a_paths_in_step: assert property (@(posedge clock) disable iff (reset)
      i_link[SECTIONS_PER_PATH].valid == q_link[SECTIONS_PER_PATH].valid)
      else $error("in-phase and quadrature chains finished apart");

   a_chain_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##(CHAIN_LATENCY) chain_done)
      else $error("chain did not finish on time");

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> busy_ff && !pend_valid_ff)
      else $error("chain finished with no sample in flight or slot taken");

   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("parked word without a word in the output register");

endmodule

`default_nettype wire

// ----- rtl/aqp_cell.sv -----
// One second-order allpass section: y = c*(x + y[t-2]) - x[t-2], with its history.
// Depends on aqp_pkg.
`default_nettype none

module aqp_cell import aqp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire aqp_link_type          link_in,
   input  wire logic [COEF_WIDTH-1:0] coef,
   output aqp_link_type               link_out
);

   localparam logic signed [PROD_WIDTH-1:0] ROUND_BIAS =
      PROD_WIDTH'(1) << (COEF_FRAC - 1);

   logic                             mul_busy_ff;
   logic                             link_valid_ff;
   logic signed [INTERNAL_WIDTH-1:0] link_data_ff;
   logic signed [PROD_WIDTH-1:0]     prod_ff;
   logic signed [PROD_WIDTH-1:0]     prod_in;
   logic signed [INTERNAL_WIDTH-1:0] x_hold_ff;
   logic signed [INTERNAL_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;

   logic signed [SUM_WIDTH-1:0]      sum;
   logic signed [COEF_WIDTH:0]       coef_s;
   logic signed [PROD_WIDTH-1:0]     rounded;
   logic signed [DIFF_WIDTH-1:0]     diff;
   logic signed [INTERNAL_WIDTH-1:0] y_sat;

   // First cycle: add and multiply.
   assign sum     = {link_in.data[INTERNAL_WIDTH-1], link_in.data}
                  + {y2_ff[INTERNAL_WIDTH-1], y2_ff};
   assign coef_s  = {1'b0, coef};
   assign prod_in = sum * coef_s;

   // Second cycle: round, drop the fraction, subtract x[t-2], clamp.
   assign rounded = prod_ff + ROUND_BIAS;
   assign diff    = {rounded[PROD_WIDTH-1], rounded[PROD_WIDTH-1:COEF_FRAC]}
                  - {{(DIFF_WIDTH-INTERNAL_WIDTH){x2_ff[INTERNAL_WIDTH-1]}}, x2_ff};
   assign y_sat   = sat_to_internal(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff   <= 1'b0;
         link_valid_ff <= 1'b0;
         x1_ff         <= '0;
         x2_ff         <= '0;
         y1_ff         <= '0;
         y2_ff         <= '0;
      end else begin
         mul_busy_ff   <= link_in.valid;
         link_valid_ff <= mul_busy_ff;
         if (mul_busy_ff) begin
            x2_ff <= x1_ff;
            x1_ff <= x_hold_ff;
            y2_ff <= y1_ff;
            y1_ff <= y_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         prod_ff   <= prod_in;
         x_hold_ff <= link_in.data;
      end
      if (mul_busy_ff) begin
         link_data_ff <= y_sat;
      end
   end

   assign link_out.valid = link_valid_ff;
   assign link_out.data  = link_data_ff;

endmodule

`default_nettype wire
